FILE: src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Depends on nothing; every other file of the block refers to it by scoped names.
package spq_pkg;

    // Number of entries the queue can hold.
    localparam int CAPACITY = 64;
    // Width of the fill count, which must also hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Number of levels in the parallel prefix network over the cells.
    localparam int PFX_LVL = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int PRI_W = 32;
    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Source of a cell's next contents.
    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_NEW   = 2'd1,
        SEL_LEFT  = 2'd2,
        SEL_RIGHT = 2'd3
    } cell_sel_t;

    // One queue entry; the key holds x in bits 7..0, y in 15..8,
    // symbol in 23..16 and speed in 31..24.
    typedef struct packed {
        logic [PRI_W-1:0] priority_val;
        logic [KEY_W-1:0] key;
    } entry_t;

    // Comparison results a cell reports against the current request.
    typedef struct packed {
        logic ge;     // valid and stored priority >= requested priority
        logic gt;     // valid and stored priority >  requested priority
        logic match;  // valid and stored key equals requested key
    } cell_flags_t;

endpackage

FILE: src/spq_cell.sv
// One storage cell of the sorted queue: an entry register, its comparators
// and the selector that loads it from the request or a neighbour. Uses spq_pkg.
module spq_cell (
    input  logic                       clk,
    input  logic                       valid,
    input  spq_pkg::cell_sel_t         sel,
    input  spq_pkg::entry_t            new_entry,
    input  spq_pkg::entry_t            left_entry,
    input  spq_pkg::entry_t            right_entry,
    output spq_pkg::entry_t            entry,
    output spq_pkg::cell_flags_t       flags
);

    spq_pkg::entry_t entry_reg;

    // The flags compare the stored entry with the request that is on offer.
    always_comb
    begin
        flags.ge    = valid && (entry_reg.priority_val >= new_entry.priority_val);
        flags.gt    = valid && (entry_reg.priority_val >  new_entry.priority_val);
        flags.match = valid && (entry_reg.key == new_entry.key);
    end

    always_ff @(posedge clk)
    begin
        case (sel)
            spq_pkg::SEL_NEW:   entry_reg <= new_entry;
            spq_pkg::SEL_LEFT:  entry_reg <= left_entry;
            spq_pkg::SEL_RIGHT: entry_reg <= right_entry;
            default:            entry_reg <= entry_reg;
        endcase
    end

    assign entry = entry_reg;

endmodule

FILE: src/spq_prefix.sv
// Inclusive prefix OR across the row of cells, built as a log-depth network.
// Uses spq_pkg for the row length and the number of levels.
module spq_prefix (
    input  logic [spq_pkg::CAPACITY-1:0] bits_in,
    output logic [spq_pkg::CAPACITY-1:0] bits_out
);

    logic [spq_pkg::CAPACITY-1:0] lvl [0:spq_pkg::PFX_LVL];

    // Each level ORs in the partial result from a distance that doubles.
    always_comb
    begin
        lvl[0] = bits_in;
        for (int k = 0; k < spq_pkg::PFX_LVL; k++)
        begin
            for (int i = 0; i < spq_pkg::CAPACITY; i++)
            begin
                if (i >= (1 << k))
                begin
                    lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
                end
                else
                begin
                    lvl[k+1][i] = lvl[k][i];
                end
            end
        end
    end

    assign bits_out = lvl[spq_pkg::PFX_LVL];

endmodule

FILE: src/sorted_priority_queue_with_remove.sv
// Sorted priority queue with keyed remove and presence query: a row of cells.
// Latency: the result strobe done rises in the cycle after the request is taken.
// Throughput: one request per cycle; busy is always low.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the fill count and the strobe; cell contents are left as they are.
// Depends on spq_pkg, spq_cell and spq_prefix.
module sorted_priority_queue_with_remove (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] priority_req,
    input  logic [7:0]  entry_x,
    input  logic [7:0]  entry_y,
    input  logic [7:0]  entry_symbol,
    input  logic [7:0]  entry_speed,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] out_priority,
    output logic [7:0]  out_x,
    output logic [7:0]  out_y,
    output logic [7:0]  out_symbol,
    output logic [7:0]  out_speed,
    output logic        found,
    output logic        empty_after
);

    localparam int CAP = spq_pkg::CAPACITY;
    localparam int CW  = spq_pkg::CNT_W;

    // Entries are kept in ascending priority from cell 0 (the head). Every
    // cell compares its entry with the request in parallel; each cell then
    // picks hold, new entry or shift from its flags, its left neighbour's,
    // the head's and the match prefix. A pop shifts every cell one place, a
    // push those past its insertion point, a remove from the first match on.

    logic [CW-1:0]          fill_reg;
    logic [CW-1:0]          fill_next;
    logic                   done_reg;
    spq_pkg::status_t       status_reg;
    spq_pkg::status_t       status_next;
    spq_pkg::entry_t        out_entry_reg;
    spq_pkg::entry_t        out_entry_next;
    logic                   found_reg;
    logic                   found_next;
    logic                   empty_reg;

    spq_pkg::op_t           op_in;
    spq_pkg::entry_t        req_entry;
    spq_pkg::entry_t        cell_q     [CAP];
    spq_pkg::cell_flags_t   cell_flags [CAP];
    spq_pkg::cell_sel_t     cell_sel   [CAP];
    logic [CAP-1:0]         valid_vec;
    logic [CAP-1:0]         ge_vec;
    logic [CAP-1:0]         match_vec;
    logic [CAP-1:0]         match_upto;

    logic                   is_empty;
    logic                   is_full;
    logic                   head_front;
    logic                   any_match;
    logic                   push_ok;
    logic                   pop_ok;
    logic                   remove_ok;

    assign op_in                  = spq_pkg::op_t'(op);
    assign req_entry.priority_val = priority_req;
    assign req_entry.key          = {entry_speed, entry_symbol, entry_y, entry_x};

    assign is_empty  = (fill_reg == CW'(0));
    assign is_full   = (fill_reg == CW'(CAP));
    // A push goes to the head only when the head's priority is strictly
    // above the new one, or when the queue is empty.
    assign head_front = is_empty || cell_flags[0].gt;
    assign any_match  = match_upto[CAP-1];

    assign push_ok   = start && (op_in == spq_pkg::OP_PUSH) && !is_full;
    assign pop_ok    = start && (op_in == spq_pkg::OP_POP) && !is_empty;
    assign remove_ok = start && (op_in == spq_pkg::OP_REMOVE) && any_match;

    // The row of cells.
    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++)
        begin : g_cell
            spq_pkg::entry_t left_e;
            spq_pkg::entry_t right_e;

            assign valid_vec[gi] = (fill_reg > CW'(gi));
            assign ge_vec[gi]    = cell_flags[gi].ge;
            assign match_vec[gi] = cell_flags[gi].match;

            if (gi == 0)
            begin : g_first
                assign left_e = req_entry;
            end
            else
            begin : g_mid_l
                assign left_e = cell_q[gi-1];
            end

            if (gi == CAP - 1)
            begin : g_last
                assign right_e = cell_q[gi];
            end
            else
            begin : g_mid_r
                assign right_e = cell_q[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .valid       (valid_vec[gi]),
                .sel         (cell_sel[gi]),
                .new_entry   (req_entry),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (cell_q[gi]),
                .flags       (cell_flags[gi])
            );
        end
    endgenerate

    // Marks every cell at or beyond the first matching key, so a remove
    // closes the gap from the first match onwards only.
    spq_prefix u_prefix (
        .bits_in  (match_vec),
        .bits_out (match_upto)
    );

    // Per-cell selection. For a push past the head, the sorted order makes
    // the ge flags monotone from cell 1 on: the insertion point is the first
    // cell with ge set, or the first empty cell when none is set. Cells past
    // the insertion point take their left neighbour's entry.
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            cell_sel[i] = spq_pkg::SEL_HOLD;
            if (push_ok)
            begin
                if (i == 0)
                begin
                    cell_sel[i] = head_front ? spq_pkg::SEL_NEW : spq_pkg::SEL_HOLD;
                end
                else if (head_front)
                begin
                    cell_sel[i] = spq_pkg::SEL_LEFT;
                end
                else if ((i >= 2) && ge_vec[(i >= 2) ? i - 1 : 0])
                begin
                    cell_sel[i] = spq_pkg::SEL_LEFT;
                end
                else if (ge_vec[i] || (valid_vec[(i >= 1) ? i - 1 : 0] && !valid_vec[i]))
                begin
                    cell_sel[i] = spq_pkg::SEL_NEW;
                end
            end
            else if (pop_ok)
            begin
                cell_sel[i] = spq_pkg::SEL_RIGHT;
            end
            else if (remove_ok && match_upto[i])
            begin
                cell_sel[i] = spq_pkg::SEL_RIGHT;
            end
        end
    end

    // Fill count and result for the request on offer.
    always_comb
    begin
        fill_next      = fill_reg;
        status_next    = spq_pkg::ST_OK;
        out_entry_next = '0;
        found_next     = 1'b0;
        if (push_ok)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (pop_ok || remove_ok)
        begin
            fill_next = fill_reg - CW'(1);
        end

        case (op_in)
            spq_pkg::OP_PUSH:
            begin
                if (is_full)
                begin
                    status_next = spq_pkg::ST_PUSH_FULL;
                end
            end
            spq_pkg::OP_POP:
            begin
                if (is_empty)
                begin
                    status_next = spq_pkg::ST_POP_EMPTY;
                end
                else
                begin
                    out_entry_next = cell_q[0];
                end
            end
            spq_pkg::OP_REMOVE:
            begin
                if (!any_match)
                begin
                    status_next = spq_pkg::ST_NOT_FOUND;
                end
            end
            spq_pkg::OP_QUERY:
            begin
                found_next = any_match;
            end
            default:
            begin
                status_next = spq_pkg::ST_OK;
            end
        endcase
    end

    // Control state: fill count and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Result payload, loaded with each request.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg    <= status_next;
            out_entry_reg <= out_entry_next;
            found_reg     <= found_next;
            empty_reg     <= (fill_next == CW'(0));
        end
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_priority = out_entry_reg.priority_val;
    assign out_x        = out_entry_reg.key[7:0];
    assign out_y        = out_entry_reg.key[15:8];
    assign out_symbol   = out_entry_reg.key[23:16];
    assign out_speed    = out_entry_reg.key[31:24];
    assign found        = found_reg;
    assign empty_after  = empty_reg;

endmodule

FILE: bench/spq_outcome_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted priority queue: keeps a mirror of the queue contents and predicts
// one outcome for each accepted request, then compares it with the next result strobe.
// Depends on spq_pkg for the capacity and the operation and status codes.
module spq_outcome_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] priority_req,
    input  logic [7:0]  entry_x,
    input  logic [7:0]  entry_y,
    input  logic [7:0]  entry_symbol,
    input  logic [7:0]  entry_speed,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [31:0] out_priority,
    input  logic [7:0]  out_x,
    input  logic [7:0]  out_y,
    input  logic [7:0]  out_symbol,
    input  logic [7:0]  out_speed,
    input  logic        found,
    input  logic        empty_after,
    output int          mismatches,
    output int          outstanding,
    output int          results_seen,
    output int          peak_fill
);

    typedef struct packed {
        spq_pkg::status_t status;
        logic [31:0]      pri;
        logic [31:0]      key;
        logic             found;
        logic             empty;
    } outcome_t;

    // Mirror of the queue, head at index zero.
    logic [31:0] mirror_pri [spq_pkg::CAPACITY];
    logic [31:0] mirror_key [spq_pkg::CAPACITY];
    int          fill;

    outcome_t    outcome_queue [$];

    function automatic int locate_key(logic [31:0] key);
        int idx;
        for (idx = 0; idx < fill; idx++)
        begin
            if (mirror_key[idx] == key)
                return idx;
        end
        return -1;
    endfunction

    // Applies one request to the mirror and returns the outcome the block should report.
    function automatic outcome_t predict_outcome(spq_pkg::op_t kind, logic [31:0] pri,
                                                 logic [31:0] key);
        outcome_t res;
        int       pos;
        int       idx;
        res = '0;
        res.status = spq_pkg::ST_OK;
        case (kind)
            spq_pkg::OP_PUSH:
            begin
                if (fill >= spq_pkg::CAPACITY)
                    res.status = spq_pkg::ST_PUSH_FULL;
                else
                begin
                    // The head is only displaced by a strictly lower priority.
                    if (fill == 0 || mirror_pri[0] > pri)
                        pos = 0;
                    else
                    begin
                        pos = 1;
                        while (pos < fill && mirror_pri[pos] < pri)
                            pos++;
                    end
                    for (idx = fill; idx > pos; idx--)
                    begin
                        mirror_pri[idx] = mirror_pri[idx - 1];
                        mirror_key[idx] = mirror_key[idx - 1];
                    end
                    mirror_pri[pos] = pri;
                    mirror_key[pos] = key;
                    fill++;
                end
            end
            spq_pkg::OP_POP:
            begin
                if (fill == 0)
                    res.status = spq_pkg::ST_POP_EMPTY;
                else
                begin
                    res.pri = mirror_pri[0];
                    res.key = mirror_key[0];
                    for (idx = 1; idx < fill; idx++)
                    begin
                        mirror_pri[idx - 1] = mirror_pri[idx];
                        mirror_key[idx - 1] = mirror_key[idx];
                    end
                    fill--;
                end
            end
            spq_pkg::OP_REMOVE:
            begin
                pos = locate_key(key);
                if (pos < 0)
                    res.status = spq_pkg::ST_NOT_FOUND;
                else
                begin
                    for (idx = pos + 1; idx < fill; idx++)
                    begin
                        mirror_pri[idx - 1] = mirror_pri[idx];
                        mirror_key[idx - 1] = mirror_key[idx];
                    end
                    fill--;
                end
            end
            default:
                res.found = (locate_key(key) >= 0);
        endcase
        res.empty = (fill == 0);
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Results are compared before the request taken at the same edge is predicted,
    // since a strobe always belongs to an earlier request.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        outcome_t want;
        if (!rst_n)
        begin
            fill = 0;
            outcome_queue.delete();
            mismatches = 0;
            outstanding = 0;
            results_seen = 0;
            peak_fill = 0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_queue.size() == 0)
                begin
                    $error("result strobe with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = outcome_queue.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("out_priority", want.pri, out_priority);
                    check_field("out_x", 32'(want.key[7:0]), 32'(out_x));
                    check_field("out_y", 32'(want.key[15:8]), 32'(out_y));
                    check_field("out_symbol", 32'(want.key[23:16]), 32'(out_symbol));
                    check_field("out_speed", 32'(want.key[31:24]), 32'(out_speed));
                    check_field("found", 32'(want.found), 32'(found));
                    check_field("empty_after", 32'(want.empty), 32'(empty_after));
                    results_seen++;
                end
            end
            if (start && !busy)
            begin
                outcome_queue.push_back(predict_outcome(spq_pkg::op_t'(op), priority_req,
                                        {entry_speed, entry_symbol, entry_y, entry_x}));
                if (fill > peak_fill)
                    peak_fill = fill;
            end
            outstanding = outcome_queue.size();
        end
    end

endmodule

FILE: bench/sorted_priority_queue_with_remove_tb.sv
`timescale 1ns / 100ps
// Top of the sorted priority queue testbench: clock, reset, request stimulus and verdict.
// Depends on spq_pkg, the block itself and spq_outcome_checker, which does all the checking.
module sorted_priority_queue_with_remove_tb;

    localparam int POOL_SIZE = 12;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [31:0] priority_req;
    logic [7:0]  entry_x;
    logic [7:0]  entry_y;
    logic [7:0]  entry_symbol;
    logic [7:0]  entry_speed;
    logic        done;
    logic [1:0]  status;
    logic [31:0] out_priority;
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic [7:0]  out_symbol;
    logic [7:0]  out_speed;
    logic        found;
    logic        empty_after;

    int          mismatches;
    int          outstanding;
    int          results_seen;
    int          peak_fill;

    // Requests issued per operation, for the closing summary.
    int          sent_per_op [4];
    // A small set of keys is reused so that removes and queries often hit a stored entry.
    logic [31:0] key_pool [POOL_SIZE];
    // While set, requests follow each other back to back with no idle cycles.
    bit          burst;

    sorted_priority_queue_with_remove dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .priority_req (priority_req),
        .entry_x      (entry_x),
        .entry_y      (entry_y),
        .entry_symbol (entry_symbol),
        .entry_speed  (entry_speed),
        .done         (done),
        .status       (status),
        .out_priority (out_priority),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_symbol   (out_symbol),
        .out_speed    (out_speed),
        .found        (found),
        .empty_after  (empty_after)
    );

    spq_outcome_checker outcome_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .priority_req (priority_req),
        .entry_x      (entry_x),
        .entry_y      (entry_y),
        .entry_symbol (entry_symbol),
        .entry_speed  (entry_speed),
        .done         (done),
        .status       (status),
        .out_priority (out_priority),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_symbol   (out_symbol),
        .out_speed    (out_speed),
        .found        (found),
        .empty_after  (empty_after),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .peak_fill    (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: the time limit is far beyond the slowest legal run.
    initial
    begin
        #200000;
        $display("** sorted_priority_queue_with_remove: FAILED **");
        $finish;
    end

    // Issues one request. It is entered just after a rising edge and returns just after the
    // edge at which the block took the request. Start is lowered only when an idle gap
    // follows, so a back-to-back request keeps start high with a single assignment per step.
    task automatic issue(spq_pkg::op_t kind, logic [31:0] pri, logic [31:0] key);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        op           <= kind;
        priority_req <= pri;
        entry_x      <= key[7:0];
        entry_y      <= key[15:8];
        entry_symbol <= key[23:16];
        entry_speed  <= key[31:24];
        do
            @(posedge clk);
        while (busy);
        sent_per_op[kind]++;
    endtask

    // Priorities lean towards a narrow band so that equal priorities are common, with the
    // extremes and fully random values mixed in.
    function automatic logic [31:0] random_priority();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // Mostly keys from the pool; now and then a fresh random key that is very likely absent.
    function automatic logic [31:0] random_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic spq_pkg::op_t pick_op(int push_pct, int pop_pct, int remove_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return spq_pkg::OP_PUSH;
        if (roll < push_pct + pop_pct)
            return spq_pkg::OP_POP;
        if (roll < push_pct + pop_pct + remove_pct)
            return spq_pkg::OP_REMOVE;
        return spq_pkg::OP_QUERY;
    endfunction

    // A run of random requests with the given mix; what is left over goes to queries.
    // Bursts with no idle cycles are switched on and off every sixteen requests.
    task automatic run_phase(int count, int push_pct, int pop_pct, int remove_pct);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (n % 16 == 0)
                burst = ($urandom_range(0, 3) == 0);
            issue(pick_op(push_pct, pop_pct, remove_pct), random_priority(), random_key());
        end
    endtask

    initial
    begin : stimulus
        int n;
        // Every input is known from time zero; reset is held low before the first request.
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = spq_pkg::OP_QUERY;
        priority_req = '0;
        entry_x      = '0;
        entry_y      = '0;
        entry_symbol = '0;
        entry_speed  = '0;
        burst        = 1'b0;
        for (n = 0; n < 4; n++)
            sent_per_op[n] = 0;
        // The all-zero and all-one keys sit in the pool so the key extremes are stored too.
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (n = 2; n < POOL_SIZE; n++)
            key_pool[n] = $urandom;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. An empty queue first: pop, remove and query must all report it.
        issue(spq_pkg::OP_POP, 32'h0, key_pool[2]);
        issue(spq_pkg::OP_REMOVE, 32'h0, key_pool[0]);
        issue(spq_pkg::OP_QUERY, 32'h0, key_pool[1]);
        // Equal priorities: a second entry goes behind an equal head, and a third goes
        // in front of the later entry of the same priority.
        issue(spq_pkg::OP_PUSH, 32'd5, key_pool[2]);
        issue(spq_pkg::OP_PUSH, 32'd5, key_pool[3]);
        issue(spq_pkg::OP_PUSH, 32'd5, key_pool[4]);
        // A strictly lower priority takes the head; an equal one then lands behind it.
        issue(spq_pkg::OP_PUSH, 32'h0000_0000, key_pool[0]);
        issue(spq_pkg::OP_PUSH, 32'h0000_0000, key_pool[5]);
        issue(spq_pkg::OP_PUSH, 32'hFFFF_FFFF, key_pool[1]);
        // A duplicate key at a better priority, so remove must take the one nearer the head.
        issue(spq_pkg::OP_PUSH, 32'd3, key_pool[2]);
        issue(spq_pkg::OP_QUERY, 32'h0, key_pool[2]);
        issue(spq_pkg::OP_QUERY, 32'h0, key_pool[6]);
        issue(spq_pkg::OP_REMOVE, 32'h0, key_pool[2]);
        issue(spq_pkg::OP_REMOVE, 32'h0, key_pool[3]);
        issue(spq_pkg::OP_REMOVE, 32'h0, key_pool[6]);
        // Drain the queue and pop once more on empty.
        repeat (6) issue(spq_pkg::OP_POP, 32'h0, key_pool[0]);

        // Random part: a mixed start, a push-heavy phase that runs the queue into its
        // capacity and rejects pushes, a pop-heavy phase that empties it again, and a
        // final mixed phase.
        run_phase(120, 40, 25, 20);
        run_phase(140, 75, 5, 10);
        run_phase(140, 10, 70, 10);
        run_phase(100, 40, 25, 20);

        start <= 1'b0;
        // Let every outstanding result arrive, then keep the clock running to catch any strobe
        // that should not be there.
        while (outstanding != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Requests sent: %0d push, %0d pop, %0d remove, %0d query.",
                 sent_per_op[spq_pkg::OP_PUSH], sent_per_op[spq_pkg::OP_POP],
                 sent_per_op[spq_pkg::OP_REMOVE], sent_per_op[spq_pkg::OP_QUERY]);
        $display("Results compared: %0d, deepest queue fill: %0d of %0d, mismatches: %0d.",
                 results_seen, peak_fill, spq_pkg::CAPACITY, mismatches);
        if (mismatches == 0)
            $display("** sorted_priority_queue_with_remove: PASSED **");
        else
            $display("** sorted_priority_queue_with_remove: FAILED **");
        $finish;
    end

endmodule
